### rtl/core/i2cmon_pkg.sv
// Shared types and constants for the I2C bus monitor.
// No dependencies; imported by the filter, protocol and top-level modules.

package i2cmon_pkg;

   // Event codes carried on rsp_event_kind
   localparam logic [2:0] EV_START   = 3'd0;
   localparam logic [2:0] EV_RESTART = 3'd1;
   localparam logic [2:0] EV_STOP    = 3'd2;
   localparam logic [2:0] EV_ADDR    = 3'd3;
   localparam logic [2:0] EV_DATA    = 3'd4;

   // Fixed widths of the result fields
   localparam int OUT_TIME_W = 48;
   localparam int BYTE_W     = 8;
   localparam int BITCNT_W   = 4;
   localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

   // Filtered line status for one sample
   typedef struct packed {
      logic toggled;   // an edge was accepted on this sample
      logic level;     // stable level after this sample
   } line_state_type;

   // Decoded event, without the dates
   typedef struct packed {
      logic               valid;
      logic [2:0]         kind;
      logic [BYTE_W-1:0]  byte_value;
      logic               read_flag;
      logic               acked;
   } event_info_type;

endpackage

### rtl/core/i2cmon_filter.sv
// Glitch filter for one bus line: keeps the stable level and the run of
// differing samples, and dates an accepted edge at its first sample.
// Depends on i2cmon_pkg.

module i2cmon_filter #(
   parameter int TIME_WIDTH   = 48,
   parameter int FILTER_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       primed,
   input  logic                       raw,
   input  logic [FILTER_WIDTH-1:0]    min_pulse,
   input  logic [TIME_WIDTH-1:0]      sample_count,
   output i2cmon_pkg::line_state_type line_out,
   output logic [TIME_WIDTH-1:0]      edge_date
);
   import i2cmon_pkg::*;

   localparam int RUN_W  = FILTER_WIDTH + 1;
   localparam int DIFF_W = (TIME_WIDTH > RUN_W) ? TIME_WIDTH : RUN_W;

   logic             stable_ff, stable_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             toggled;
   logic [DIFF_W-1:0] diff;

   // Next stable level and run length
   always_comb begin
      stable_in = stable_ff;
      run_in    = run_ff;
      toggled   = 1'b0;
      if (!primed) begin
         stable_in = raw;
         run_in    = '0;
      end else if (raw == stable_ff) begin
         run_in = '0;
      end else if (run_ff >= RUN_W'(min_pulse)) begin
         toggled   = 1'b1;
         stable_in = raw;
         run_in    = '0;
      end else begin
         run_in = run_ff + RUN_W'(1);
      end
   end

   // Edge is dated at its first differing sample, modulo the time width
   assign diff      = DIFF_W'(sample_count) - DIFF_W'(run_ff);
   assign edge_date = diff[TIME_WIDTH-1:0];

   assign line_out.toggled = toggled;
   assign line_out.level   = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (step) begin
         run_ff <= run_in;
      end
   end

   // Stable level is taken from the first sample, no reset value needed
   always_ff @(posedge clock) begin
      if (step) begin
         stable_ff <= stable_in;
      end
   end

endmodule

### rtl/core/i2cmon_proto.sv
// I2C protocol decoder: start, restart and stop detection, bit shifting
// and byte framing on the filtered line edges. Depends on i2cmon_pkg.

module i2cmon_proto #(
   parameter int TIME_WIDTH = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  i2cmon_pkg::line_state_type scl,
   input  i2cmon_pkg::line_state_type sda,
   input  logic [TIME_WIDTH-1:0]      scl_date,
   input  logic [TIME_WIDTH-1:0]      sda_date,
   output i2cmon_pkg::event_info_type info,
   output logic [TIME_WIDTH-1:0]      first_date,
   output logic [TIME_WIDTH-1:0]      last_date
);
   import i2cmon_pkg::*;

   logic                start_seen_ff, start_seen_in;
   logic                stop_seen_ff, stop_seen_in;
   logic                first_byte_ff, first_byte_in;
   logic [BITCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [TIME_WIDTH-1:0] frame_start_ff, frame_start_in;

   logic is_start, is_stop, is_bit;

   // Conditions judged on the post-edge levels
   assign is_start = !scl.toggled && scl.level && sda.toggled && !sda.level;
   assign is_stop  = !scl.toggled && scl.level && sda.toggled && sda.level
                     && start_seen_ff;
   assign is_bit   = scl.toggled && scl.level && start_seen_ff;

   always_comb begin
      start_seen_in  = start_seen_ff;
      stop_seen_in   = stop_seen_ff;
      first_byte_in  = first_byte_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      frame_start_in = frame_start_ff;
      info           = '0;
      first_date     = sda_date;
      last_date      = sda_date;
      if (is_start) begin
         // start or restart; a partial byte is dropped
         info.valid    = 1'b1;
         info.kind     = stop_seen_ff ? EV_START : EV_RESTART;
         bit_count_in  = '0;
         shift_in      = '0;
         first_byte_in = 1'b1;
         start_seen_in = 1'b1;
         stop_seen_in  = 1'b0;
      end else if (is_stop) begin
         info.valid    = 1'b1;
         info.kind     = EV_STOP;
         start_seen_in = 1'b0;
         stop_seen_in  = 1'b1;
      end else if (is_bit) begin
         if (bit_count_ff == '0) begin
            frame_start_in = scl_date;
         end
         if (bit_count_ff < BITS_PER_BYTE) begin
            bit_count_in = bit_count_ff + BITCNT_W'(1);
            shift_in     = {shift_ff[BYTE_W-2:0], sda.level};
         end else begin
            // ninth bit: acknowledge
            info.valid      = 1'b1;
            info.kind       = first_byte_ff ? EV_ADDR : EV_DATA;
            info.byte_value = shift_ff;
            info.read_flag  = first_byte_ff & shift_ff[0];
            info.acked      = !sda.level;
            first_date      = frame_start_ff;
            last_date       = scl_date;
            first_byte_in   = 1'b0;
            bit_count_in    = '0;
            shift_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_seen_ff  <= 1'b0;
         stop_seen_ff   <= 1'b1;
         first_byte_ff  <= 1'b1;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         frame_start_ff <= '0;
      end else if (step) begin
         start_seen_ff  <= start_seen_in;
         stop_seen_ff   <= stop_seen_in;
         first_byte_ff  <= first_byte_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         frame_start_ff <= frame_start_in;
      end
   end

   // Bit counter never runs past the ack bit
   a_bitcnt_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BITS_PER_BYTE)
      else $error("bit counter out of range");

   // Start and stop flags are never both set
   a_start_stop_excl: assert property (@(posedge clock) disable iff (reset)
      !(start_seen_ff && stop_seen_ff))
      else $error("start and stop flags both set");

   // A byte result always follows at least one start
   a_byte_after_start: assert property (@(posedge clock) disable iff (reset)
      (step && info.valid && (info.kind == EV_ADDR || info.kind == EV_DATA))
      |-> start_seen_ff)
      else $error("byte reported outside a transfer");

endmodule

### rtl/core/i2c_bus_monitor.sv
// Passive I2C bus monitor: one SCL/SDA sample per request, with a
// per-line glitch filter and a decoder for start, restart, stop and bytes.
// Depends on i2cmon_pkg, i2cmon_filter and i2cmon_proto.
//
// Each accepted request is one bus sample. A request is taken every clock
// unless a result is waiting under rsp_stall with a sample held behind it.
// A sample passes an input register, then the filters and decoder update
// their state and any event lands in the result register, which drives
// rsp_valid. Edges shorter than or equal to csr_min_pulse_samples samples
// are dropped; accepted edges are dated at their first sample, so events
// appear min_pulse_samples samples after the date they carry. The very
// first sample after reset only primes the line levels. Dates count
// samples modulo 2^TIME_WIDTH. The user must write the register only
// while the monitor is idle; the block itself does not enforce this.

module i2c_bus_monitor #(
   parameter int TIME_WIDTH   = 48,
   parameter int FILTER_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // sample requests
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_scl_level,
   input  logic                    req_sda_level,
   // events
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_event_kind,
   output logic [7:0]              rsp_byte_value,
   output logic                    rsp_read_flag,
   output logic                    rsp_acked,
   output logic [47:0]             rsp_first_sample,
   output logic [47:0]             rsp_last_sample,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [FILTER_WIDTH-1:0] csr_min_pulse_samples
);
   import i2cmon_pkg::*;

   localparam int EXT_W = (TIME_WIDTH > OUT_TIME_W) ? TIME_WIDTH : OUT_TIME_W;

   logic                    in_valid_ff, in_valid_in;
   logic                    in_scl_ff, in_sda_ff;
   logic                    primed_ff;
   logic [TIME_WIDTH-1:0]   sample_counter_ff;
   logic [FILTER_WIDTH-1:0] min_pulse_ff;
   logic                    out_valid_ff, out_valid_in;
   event_info_type          out_info_ff;
   logic [OUT_TIME_W-1:0]   out_first_ff, out_last_ff;

   logic                    step, req_take;
   line_state_type          scl_line, sda_line;
   logic [TIME_WIDTH-1:0]   scl_date, sda_date, first_date, last_date;
   event_info_type          info;
   logic [EXT_W-1:0]        first_ext, last_ext;

   // Handshake: the stage advances when the result register can take
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step ? info.valid : (out_valid_ff && rsp_stall);

   // Line filters
   i2cmon_filter #(
      .TIME_WIDTH   (TIME_WIDTH),
      .FILTER_WIDTH (FILTER_WIDTH)
   ) u_scl_filter (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .primed       (primed_ff),
      .raw          (in_scl_ff),
      .min_pulse    (min_pulse_ff),
      .sample_count (sample_counter_ff),
      .line_out     (scl_line),
      .edge_date    (scl_date)
   );

   i2cmon_filter #(
      .TIME_WIDTH   (TIME_WIDTH),
      .FILTER_WIDTH (FILTER_WIDTH)
   ) u_sda_filter (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .primed       (primed_ff),
      .raw          (in_sda_ff),
      .min_pulse    (min_pulse_ff),
      .sample_count (sample_counter_ff),
      .line_out     (sda_line),
      .edge_date    (sda_date)
   );

   // Bus protocol decoder
   i2cmon_proto #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_proto (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .scl        (scl_line),
      .sda        (sda_line),
      .scl_date   (scl_date),
      .sda_date   (sda_date),
      .info       (info),
      .first_date (first_date),
      .last_date  (last_date)
   );

   // Dates onto the fixed 48-bit result fields
   assign first_ext = EXT_W'(first_date);
   assign last_ext  = EXT_W'(last_date);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         primed_ff         <= 1'b0;
         sample_counter_ff <= '0;
         min_pulse_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            primed_ff         <= 1'b1;
            sample_counter_ff <= sample_counter_ff + TIME_WIDTH'(1);
         end
         if (csr_valid && csr_ready) begin
            min_pulse_ff <= csr_min_pulse_samples;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_scl_ff <= req_scl_level;
         in_sda_ff <= req_sda_level;
      end
      if (step && info.valid) begin
         out_info_ff  <= info;
         out_first_ff <= first_ext[OUT_TIME_W-1:0];
         out_last_ff  <= last_ext[OUT_TIME_W-1:0];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_info_ff.kind;
   assign rsp_byte_value   = out_info_ff.byte_value;
   assign rsp_read_flag    = out_info_ff.read_flag;
   assign rsp_acked        = out_info_ff.acked;
   assign rsp_first_sample = out_first_ff;
   assign rsp_last_sample  = out_last_ff;

   // Stall toward the sampler only when a sample is held back
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a blocked sample");

   // Sample counter advances once per processed sample
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      step |=> (sample_counter_ff == $past(sample_counter_ff) + TIME_WIDTH'(1)))
      else $error("sample counter did not advance");

   // The priming sample never yields an event
   a_prime_silent: assert property (@(posedge clock) disable iff (reset)
      (step && !primed_ff) |-> !info.valid)
      else $error("event on the priming sample");

   // Conditions carry one date and no byte
   a_cond_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_START || rsp_event_kind == EV_RESTART
       || rsp_event_kind == EV_STOP))
      |-> (rsp_byte_value == '0 && rsp_first_sample == rsp_last_sample))
      else $error("bus condition with byte payload");

endmodule

### dv/testbench.sv
// Testbench for the I2C bus monitor: streams SCL/SDA samples and checks
// every decoded event against a cycle-free predictor of the monitor.
// Depends on i2cmon_pkg and i2c_bus_monitor from the RTL.
`timescale 1ns / 100ps

module testbench;
   import i2cmon_pkg::*;

   localparam int TIME_W           = 48;
   localparam int FILT_W           = 16;
   localparam int LN_SCL           = 0;
   localparam int LN_SDA           = 1;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 6;
   localparam int MAX_REPORTS      = 10;
   localparam int PHASE_ITEMS      = 150;
   localparam int FINAL_ITEMS      = 150;
   localparam int MIN_RAND_EVENTS  = 60;
   localparam int WIDEST_FILTER    = 65535;

   typedef struct packed {
      logic [2:0]            kind;
      logic [BYTE_W-1:0]     value;
      logic                  rd;
      logic                  ack;
      logic [OUT_TIME_W-1:0] first_date;
      logic [OUT_TIME_W-1:0] last_date;
   } bus_event_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_scl_level = 1'b1;
   logic              req_sda_level = 1'b1;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_event_kind;
   logic [7:0]        rsp_byte_value;
   logic              rsp_read_flag;
   logic              rsp_acked;
   logic [47:0]       rsp_first_sample;
   logic [47:0]       rsp_last_sample;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [FILT_W-1:0] csr_min_pulse_samples = '0;

   i2c_bus_monitor #(
      .TIME_WIDTH   (TIME_W),
      .FILTER_WIDTH (FILT_W)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_scl_level         (req_scl_level),
      .req_sda_level         (req_sda_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_byte_value        (rsp_byte_value),
      .rsp_read_flag         (rsp_read_flag),
      .rsp_acked             (rsp_acked),
      .rsp_first_sample      (rsp_first_sample),
      .rsp_last_sample       (rsp_last_sample),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_min_pulse_samples (csr_min_pulse_samples)
   );

   always #4 clock = ~clock;

   // Monitor shadow state
   bit [FILT_W-1:0] glitch_limit;
   bit              primed;
   bit              line_level [2];
   bit [16:0]       line_run [2];
   bit [TIME_W-1:0] line_date [2];
   bit [TIME_W-1:0] sample_idx;
   bit              in_frame;
   bit              bus_released = 1'b1;
   bit              addr_pending = 1'b1;
   bit [3:0]        bits_taken;
   bit [7:0]        shift_reg;
   bit [TIME_W-1:0] byte_start;

   bus_event_type pending_events [$];
   int         events_predicted;
   int         items_sent;
   int         mismatch_count;
   bit         cur_scl = 1'b1;
   bit         cur_sda = 1'b1;
   bit         req_gaps_on = 1'b1;
   bit         rsp_bursts_on = 1'b1;
   int         hold_req;
   int         hold_served;
   int         hold_left;
   int         stall_left;
   int         quiet_cycles;

   // Glitch filter for one line; returns 1 when an edge is accepted
   function automatic bit filter_line(int ln, bit raw);
      if (raw == line_level[ln]) begin
         line_run[ln] = '0;
         return 1'b0;
      end
      line_run[ln] = line_run[ln] + 1'b1;
      if (int'(line_run[ln]) >= int'(glitch_limit) + 1) begin
         // dated at the first differing sample
         line_date[ln] = sample_idx - {31'd0, line_run[ln]} + 48'd1;
         line_level[ln] = raw;
         line_run[ln] = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void push_event(logic [2:0] kind, logic [7:0] value, logic rd,
                                      logic ack, logic [47:0] first_d,
                                      logic [47:0] last_d);
      bus_event_type ev;
      ev.kind       = kind;
      ev.value      = value;
      ev.rd         = rd;
      ev.ack        = ack;
      ev.first_date = first_d;
      ev.last_date  = last_d;
      pending_events = {pending_events, ev};
      events_predicted++;
   endfunction

   // Predict the event, if any, caused by one bus sample
   function automatic void decode_sample(bit scl, bit sda);
      bit scl_edge;
      bit sda_edge;
      if (!primed) begin
         primed = 1'b1;
         line_level[LN_SCL] = scl;
         line_level[LN_SDA] = sda;
         sample_idx = sample_idx + 1'b1;
         return;
      end
      scl_edge = filter_line(LN_SCL, scl);
      sda_edge = filter_line(LN_SDA, sda);
      if (!scl_edge && line_level[LN_SCL] && sda_edge && !line_level[LN_SDA]) begin
         // start or restart; any partial byte is dropped
         push_event(bus_released ? EV_START : EV_RESTART, 8'd0, 1'b0, 1'b0,
                    line_date[LN_SDA], line_date[LN_SDA]);
         bits_taken   = '0;
         shift_reg    = '0;
         addr_pending = 1'b1;
         in_frame     = 1'b1;
         bus_released = 1'b0;
      end else if (!scl_edge && line_level[LN_SCL] && sda_edge && line_level[LN_SDA]
                   && in_frame) begin
         push_event(EV_STOP, 8'd0, 1'b0, 1'b0, line_date[LN_SDA], line_date[LN_SDA]);
         in_frame     = 1'b0;
         bus_released = 1'b1;
      end else if (scl_edge && line_level[LN_SCL] && in_frame) begin
         if (bits_taken == 0)
            byte_start = line_date[LN_SCL];
         if (bits_taken < BITS_PER_BYTE) begin
            bits_taken = bits_taken + 1'b1;
            shift_reg  = {shift_reg[6:0], line_level[LN_SDA]};
         end else begin
            // ninth bit is the acknowledge, low means acked
            push_event(addr_pending ? EV_ADDR : EV_DATA, shift_reg,
                       addr_pending ? shift_reg[0] : 1'b0, !line_level[LN_SDA],
                       byte_start, line_date[LN_SCL]);
            addr_pending = 1'b0;
            bits_taken   = '0;
            shift_reg    = '0;
         end
      end
      sample_idx = sample_idx + 1'b1;
   endfunction

   // Offer one sample request, wait for acceptance, then predict
   task automatic send_sample(bit scl, bit sda);
      int gap;
      if (req_gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_scl_level <= scl;
      req_sda_level <= sda;
      do @(posedge clock); while (req_stall);
      decode_sample(scl, sda);
      items_sent++;
      cur_scl = scl;
      cur_sda = sda;
   endtask

   // Stop offering requests and let every expected event come out
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_filter(int value);
      drain_pipeline();
      csr_valid             <= 1'b1;
      csr_min_pulse_samples <= value[FILT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      glitch_limit = value[FILT_W-1:0];
   endtask

   // Hold a bus level long enough to pass the filter, sometimes with a glitch
   task automatic hold_level(bit scl, bit sda);
      int  n;
      int  glen;
      bit  on_scl;
      n = int'(glitch_limit) + 1 + $urandom_range(0, 2);
      repeat (n) send_sample(scl, sda);
      if (glitch_limit != 0 && $urandom_range(0, 5) == 0) begin
         glen   = $urandom_range(1, int'(glitch_limit));
         on_scl = ($urandom_range(0, 1) == 1);
         repeat (glen) send_sample(on_scl ? !scl : scl, on_scl ? sda : !sda);
         send_sample(scl, sda);
      end
   endtask

   task automatic line_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) send_sample($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
   endtask

   // One transfer: start, bytes, optional restarts, stop; sometimes cut mid-byte
   task automatic bus_transaction();
      int       nbytes;
      int       cut;
      bit [7:0] value;
      bit       ack_low;
      bit       bit_level;
      bit       more;
      if (!(cur_scl && cur_sda)) begin
         hold_level(1'b0, cur_sda);
         hold_level(1'b0, 1'b1);
      end
      hold_level(1'b1, 1'b1);
      hold_level(1'b1, 1'b0);
      do begin
         nbytes = $urandom_range(1, 4);
         cut    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 9;
         for (int i = 0; i < nbytes; i++) begin
            value = $urandom_range(0, 255);
            if ($urandom_range(0, 7) == 0)
               value = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            ack_low = ($urandom_range(0, 3) != 0);
            for (int b = 0; b < 9; b++) begin
               if (i == nbytes - 1 && b == cut)
                  break;
               bit_level = (b < 8) ? value[7 - b] : !ack_low;
               hold_level(1'b0, bit_level);
               hold_level(1'b1, bit_level);
            end
         end
         more = ($urandom_range(0, 3) == 0);
         if (more) begin
            hold_level(1'b0, 1'b1);
            hold_level(1'b1, 1'b1);
            hold_level(1'b1, 1'b0);
         end
      end while (more);
      hold_level(1'b0, 1'b0);
      hold_level(1'b1, 1'b0);
      hold_level(1'b1, 1'b1);
   endtask

   // Byte with no filtering: SDA set as SCL falls, sampled as SCL rises
   task automatic send_byte_bits(bit [7:0] value, bit ack_low);
      bit bit_level;
      for (int b = 0; b < 9; b++) begin
         bit_level = (b < 8) ? value[7 - b] : !ack_low;
         send_sample(1'b0, bit_level);
         send_sample(1'b1, bit_level);
      end
   endtask

   // Conditions and bytes with the filter off
   task automatic test_bus_conditions();
      send_sample(1'b1, 1'b1);            // first sample only primes
      send_sample(1'b1, 1'b0);            // start
      send_byte_bits(8'hA5, 1'b1);        // address, read, acked
      send_byte_bits(8'hFF, 1'b0);        // data, not acked
      send_sample(1'b0, 1'b1);            // two bits of a byte, then stop and start
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);            // start drops the partial byte
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);            // stop
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);            // SCL rise outside a frame: ignored
      send_sample(1'b1, 1'b1);            // SDA rise outside a frame: ignored
   endtask

   // Lower the filter while an SDA pulse is still pending
   task automatic test_threshold_lowered();
      set_filter(6);
      repeat (4) send_sample(1'b1, 1'b0);
      set_filter(2);
      send_sample(1'b1, 1'b0);
      repeat (3) send_sample(1'b1, 1'b1);
   endtask

   // Widest filter: long pulses on both lines are all dropped as glitches
   task automatic test_widest_filter();
      set_filter(WIDEST_FILTER);
      req_gaps_on = 1'b0;
      repeat (3) send_sample(1'b1, 1'b1);
      repeat (40) send_sample(1'b1, 1'b0);
      repeat (12) send_sample(1'b0, 1'b0);
      repeat (3) send_sample(1'b1, 1'b0);
   endtask

   // Receiver holds off while conditions keep coming, so the input backs up
   task automatic test_backpressure();
      set_filter(0);
      req_gaps_on = 1'b0;
      hold_req++;
      repeat (40) begin
         send_sample(1'b1, 1'b1);
         send_sample(1'b1, 1'b0);
      end
   endtask

   task automatic test_random_traffic(int limit, int goal, bit idling, int event_goal);
      int first_item;
      set_filter(limit);
      req_gaps_on   = idling;
      rsp_bursts_on = idling;
      first_item    = items_sent;
      while (items_sent - first_item < goal || events_predicted < event_goal) begin
         if ($urandom_range(0, 9) == 0)
            line_noise();
         else
            bus_transaction();
      end
   endtask

   // Receiver side stalls: random bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_req) begin
         hold_served = hold_req;
         hold_left   = HOLD_OFF_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_bursts_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // Compare each accepted event with the oldest prediction
   always @(posedge clock) begin
      bus_event_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected event: kind %0d byte %0h first %0d last %0d",
                        rsp_event_kind, rsp_byte_value, rsp_first_sample,
                        rsp_last_sample);
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("byte_value", want.value, rsp_byte_value);
            check_field("read_flag", want.rd, rsp_read_flag);
            check_field("acked", want.ack, rsp_acked);
            check_field("first_sample", want.first_date, rsp_first_sample);
            check_field("last_sample", want.last_date, rsp_last_sample);
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int random_event_base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bus_conditions();
      test_threshold_lowered();
      test_widest_filter();
      test_backpressure();
      random_event_base = events_predicted;
      test_random_traffic(1, PHASE_ITEMS, 1'b1, 0);
      test_random_traffic(0, PHASE_ITEMS, 1'b0, 0);
      test_random_traffic(3, PHASE_ITEMS, 1'b1, 0);
      test_random_traffic($urandom_range(2, 4), PHASE_ITEMS, 1'b1, 0);
      test_random_traffic($urandom_range(1, 2), PHASE_ITEMS, 1'b1, 0);
      // last stretch runs without any idling
      test_random_traffic($urandom_range(0, 2), FINAL_ITEMS, 1'b0,
                          random_event_base + MIN_RAND_EVENTS);
      drain_pipeline();
      if (pending_events.size() != 0)
         $display("%0d expected events never arrived", pending_events.size());
      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
rtl/core/i2cmon_pkg.sv
rtl/core/i2cmon_filter.sv
rtl/core/i2cmon_proto.sv
rtl/core/i2c_bus_monitor.sv
dv/testbench.sv
